/* src/met_pkg.sv */
`timescale 1ns / 1ps

package met_pkg;

   localparam int DEF_DIM_BITS  = 12;
   localparam int DEF_FRAC_BITS = 28;
   localparam int DEF_ITER_BITS = 16;

   // fixed field and register widths
   localparam int PIX_W      = 12;
   localparam int COUNT_W    = 16;
   localparam int COL_OFS_W  = 13;
   localparam int ROW_OFS_W  = 12;
   localparam int STEP_W     = 31;
   localparam int LIMIT_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   // step registers are unsigned Q1.30
   localparam int STEP_FRAC = 30;

   localparam logic [COL_OFS_W-1:0] RST_COL_OFS = 13'd48;
   localparam logic [ROW_OFS_W-1:0] RST_ROW_OFS = 12'd32;
   localparam logic [STEP_W-1:0]    RST_X_STEP  = 31'd33554432;
   localparam logic [STEP_W-1:0]    RST_Y_STEP  = 31'd33554432;
   localparam logic [LIMIT_W-1:0]   RST_LIMIT   = 16'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMN_OFFSET   = 3'd0,
      CSR_ROW_OFFSET      = 3'd1,
      CSR_X_STEP          = 3'd2,
      CSR_Y_STEP          = 3'd3,
      CSR_ITERATION_LIMIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COL_OFS_W-1:0] column_offset;
      logic [ROW_OFS_W-1:0] row_offset;
      logic [STEP_W-1:0]    x_step;
      logic [STEP_W-1:0]    y_step;
      logic [LIMIT_W-1:0]   iteration_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      S_WAIT      = 4'd0,
      S_MAP       = 4'd1,
      S_CONV      = 4'd2,
      S_DISC_MUL  = 4'd3,
      S_DISC_ACC  = 4'd4,
      S_DISC_TEST = 4'd5,
      S_ITER_MUL  = 4'd6,
      S_ITER_ACC  = 4'd7,
      S_ITER_STEP = 4'd8,
      S_EMIT      = 4'd9
   } step_type;

   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_REQ      = 3'd1,
      COND_SKIP     = 3'd2,
      COND_EXIT     = 3'd3,
      COND_OUT_FREE = 3'd4
   } cond_type;

   typedef struct packed {
      logic     take_req;
      logic     load_c;
      logic     sel_disc;
      logic     disc_check;
      logic     iter_update;
      logic     emit;
      cond_type cond;
      step_type target;
      step_type next;
   } ctrl_word_type;

   typedef struct packed {
      logic skip_loop;
      logic loop_exit;
   } stat_type;

   // microprogram: jump to target when the condition holds, else go to next
   function automatic ctrl_word_type met_ucode(input step_type s);
      ctrl_word_type w;
      w = '0;
      w.cond   = COND_ALWAYS;
      w.target = S_WAIT;
      w.next   = S_WAIT;
      case (s)
         S_WAIT: begin
            w.take_req = 1'b1;
            w.cond     = COND_REQ;
            w.target   = S_MAP;
            w.next     = S_WAIT;
         end
         S_MAP: begin
            w.target = S_CONV;
         end
         S_CONV: begin
            w.load_c = 1'b1;
            w.target = S_DISC_MUL;
         end
         S_DISC_MUL: begin
            w.sel_disc = 1'b1;
            w.target   = S_DISC_ACC;
         end
         S_DISC_ACC: begin
            w.target = S_DISC_TEST;
         end
         S_DISC_TEST: begin
            w.disc_check = 1'b1;
            w.cond       = COND_SKIP;
            w.target     = S_EMIT;
            w.next       = S_ITER_MUL;
         end
         S_ITER_MUL: begin
            w.target = S_ITER_ACC;
         end
         S_ITER_ACC: begin
            w.target = S_ITER_STEP;
         end
         S_ITER_STEP: begin
            w.iter_update = 1'b1;
            w.cond        = COND_EXIT;
            w.target      = S_EMIT;
            w.next        = S_ITER_MUL;
         end
         S_EMIT: begin
            w.emit   = 1'b1;
            w.cond   = COND_OUT_FREE;
            w.target = S_WAIT;
            w.next   = S_EMIT;
         end
         default: begin
            w.target = S_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

/* src/met_if.sv */
`timescale 1ns / 1ps

interface met_req_if import met_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_row;
   logic [PIX_W-1:0] pixel_col;

   modport source (output valid, output pixel_row, output pixel_col, input ready);
   modport sink (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface met_rsp_if import met_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] iteration_count;
   logic               bulb_shortcut;

   modport source (output valid, output iteration_count, output bulb_shortcut, input ready);
   modport sink (input valid, input iteration_count, input bulb_shortcut, output ready);
endinterface

/* src/met_qmul.sv */
`timescale 1ns / 1ps

// Q4.F product, floor rounding and saturation; two register stages.
module met_qmul import met_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic signed [FRAC_BITS+3:0]   a,
   input  logic signed [FRAC_BITS+3:0]   b,
   output logic signed [FRAC_BITS+3:0]   y
);

   localparam int QW  = FRAC_BITS + 4;
   localparam int H   = (QW + 1) / 2;
   localparam int HI  = QW - H;
   localparam int PW2 = 2 * QW;

   localparam logic [QW-1:0] Q_MAX_V = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] Q_MIN_V = {1'b1, {(QW-1){1'b0}}};

   logic signed [2*HI-1:0] pp_hh_ff, pp_hh_in;
   logic signed [HI+H:0]   pp_hl_ff, pp_hl_in;
   logic signed [HI+H:0]   pp_lh_ff, pp_lh_in;
   logic [2*H-1:0]         pp_ll_ff, pp_ll_in;
   logic signed [QW-1:0]   y_ff, y_in;

   logic signed [PW2-1:0]  full;
   logic signed [PW2-1:0]  shifted;

   // split into a signed high half and an unsigned low half
   always_comb begin
      pp_hh_in = $signed(a[QW-1:H]) * $signed(b[QW-1:H]);
      pp_hl_in = $signed(a[QW-1:H]) * $signed({1'b0, b[H-1:0]});
      pp_lh_in = $signed({1'b0, a[H-1:0]}) * $signed(b[QW-1:H]);
      pp_ll_in = a[H-1:0] * b[H-1:0];
   end

   always_comb begin
      full = (PW2'(pp_hh_ff) <<< (2 * H))
           + ((PW2'(pp_hl_ff) + PW2'(pp_lh_ff)) <<< H)
           + $signed(PW2'(pp_ll_ff));
      shifted = full >>> FRAC_BITS;
      if (shifted[PW2-1:QW-1] == {(PW2-QW+1){shifted[PW2-1]}}) begin
         y_in = shifted[QW-1:0];
      end else begin
         y_in = shifted[PW2-1] ? Q_MIN_V : Q_MAX_V;
      end
   end

   always_ff @(posedge clock) begin
      pp_hh_ff <= pp_hh_in;
      pp_hl_ff <= pp_hl_in;
      pp_lh_ff <= pp_lh_in;
      pp_ll_ff <= pp_ll_in;
      y_ff     <= y_in;
   end

   assign y = y_ff;

endmodule

/* src/met_dpath.sv */
`timescale 1ns / 1ps

module met_dpath import met_pkg::*; #(
   parameter int DIM_BITS  = DEF_DIM_BITS,
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   parameter int ITER_BITS = DEF_ITER_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_word_type        ctrl,
   input  cfg_type              cfg,
   input  logic                 req_take,
   input  logic [DIM_BITS-1:0]  pix_row,
   input  logic [DIM_BITS-1:0]  pix_col,
   output stat_type             stat,
   output logic [ITER_BITS-1:0] count,
   output logic                 bulb
);

   localparam int QW    = FRAC_BITS + 4;
   localparam int DW    = (DIM_BITS > COL_OFS_W ? DIM_BITS : COL_OFS_W) + 1;
   localparam int PW    = DW + STEP_W + 1;
   localparam int SAT_W = STEP_FRAC + 4;

   localparam logic [QW-1:0] Q_MAX_V = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] Q_MIN_V = {1'b1, {(QW-1){1'b0}}};
   localparam logic signed [QW+1:0] QUARTER = (QW+2)'(1) << (FRAC_BITS - 2);
   localparam logic signed [QW+1:0] FOUR    = (QW+2)'(1) << (FRAC_BITS + 2);

   function automatic logic signed [QW-1:0] sat_q(input logic signed [QW+1:0] v);
      if (v[QW+1:QW-1] == {3{v[QW+1]}}) begin
         return v[QW-1:0];
      end
      return v[QW+1] ? Q_MIN_V : Q_MAX_V;
   endfunction

   // clamp to [-8, 8) in Q4.30 terms, then rescale to F fraction bits with floor
   function automatic logic signed [QW-1:0] map_conv(input logic signed [PW-1:0] p);
      logic signed [SAT_W-1:0]    s;
      logic signed [SAT_W+QW-1:0] w;
      if (p[PW-1:SAT_W-1] == {(PW-SAT_W+1){p[PW-1]}}) begin
         s = p[SAT_W-1:0];
      end else begin
         s = p[PW-1] ? {1'b1, {(SAT_W-1){1'b0}}} : {1'b0, {(SAT_W-1){1'b1}}};
      end
      w = {s, {QW{1'b0}}};
      w = w >>> SAT_W;
      return w[QW-1:0];
   endfunction

   logic signed [DW-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic signed [PW-1:0]    px_ff, px_in, py_ff, py_in;
   logic signed [QW-1:0]    c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [QW-1:0]    z_re_ff, z_re_in, z_im_ff, z_im_in;
   logic [ITER_BITS-1:0]    count_ff, count_in;
   logic                    bulb_ff, bulb_in;

   logic [ITER_BITS-1:0]    limit;
   logic [ITER_BITS-1:0]    count_nx;
   logic signed [QW-1:0]    op0, op1;
   logic signed [QW-1:0]    sq0, sq1, cross_prod;
   logic signed [QW+1:0]    mag2;
   logic                    bulb_hit;
   logic                    escape;
   logic                    last;
   logic signed [QW-1:0]    re_new, im_new;

   assign limit    = ITER_BITS'(cfg.iteration_limit);
   assign count_nx = count_ff + ITER_BITS'(1);

   always_comb begin
      dx_in = dx_ff;
      dy_in = dy_ff;
      if (req_take) begin
         dx_in = $signed(DW'(pix_col) - DW'(cfg.column_offset));
         dy_in = $signed(DW'(pix_row) - DW'(cfg.row_offset));
      end
      px_in = dx_ff * $signed({1'b0, cfg.x_step});
      py_in = dy_ff * $signed({1'b0, cfg.y_step});
   end

   // disc test squares c_re + 1/4; a sum past 8 clamps, which still fails the test
   always_comb begin
      if (ctrl.sel_disc) begin
         op0 = sat_q((QW+2)'(c_re_ff) + QUARTER);
         op1 = c_im_ff;
      end else begin
         op0 = z_re_ff;
         op1 = z_im_ff;
      end
   end

   met_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_re (.clock(clock), .a(op0), .b(op0), .y(sq0));
   met_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_im (.clock(clock), .a(op1), .b(op1), .y(sq1));
   met_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_x (.clock(clock), .a(z_re_ff), .b(z_im_ff),
                                             .y(cross_prod));

   always_comb begin
      mag2     = (QW+2)'(sq0) + (QW+2)'(sq1);
      bulb_hit = mag2 < QUARTER;
      escape   = mag2 >= FOUR;
      last     = count_nx == limit;
      re_new   = sat_q((QW+2)'(sq0) - (QW+2)'(sq1) + (QW+2)'(c_re_ff));
      im_new   = sat_q(((QW+2)'(cross_prod) <<< 1) + (QW+2)'(c_im_ff));
   end

   always_comb begin
      c_re_in  = c_re_ff;
      c_im_in  = c_im_ff;
      z_re_in  = z_re_ff;
      z_im_in  = z_im_ff;
      count_in = count_ff;
      bulb_in  = bulb_ff;
      if (ctrl.load_c) begin
         c_re_in  = map_conv(px_ff);
         c_im_in  = map_conv(py_ff);
         z_re_in  = map_conv(px_ff);
         z_im_in  = map_conv(py_ff);
         count_in = '0;
         bulb_in  = 1'b0;
      end
      if (ctrl.disc_check) begin
         bulb_in = bulb_hit;
         if (bulb_hit) begin
            count_in = limit;
         end
      end
      if (ctrl.iter_update && !escape) begin
         z_re_in  = re_new;
         z_im_in  = im_new;
         count_in = count_nx;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      c_re_ff  <= c_re_in;
      c_im_ff  <= c_im_in;
      z_re_ff  <= z_re_in;
      z_im_ff  <= z_im_in;
      count_ff <= count_in;
      bulb_ff  <= bulb_in;
   end

   assign stat.skip_loop = bulb_hit || (limit == '0);
   assign stat.loop_exit = escape || last;
   assign count          = count_ff;
   assign bulb           = bulb_ff;

   a_loop_not_after_bulb: assert property (@(posedge clock) disable iff (reset)
      ctrl.iter_update |-> !bulb_ff)
      else $error("iteration step after disc shortcut");

   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      ctrl.iter_update |-> count_ff < limit)
      else $error("iteration count reached limit inside loop");

   a_count_advance: assert property (@(posedge clock) disable iff (reset)
      ctrl.iter_update && !escape |=> count_ff == $past(count_nx))
      else $error("count did not advance on a non-escaping step");

   a_bulb_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.disc_check && bulb_hit |=> bulb_ff && count_ff == $past(limit))
      else $error("disc shortcut did not load the limit");

endmodule

/* src/met_seq.sv */
`timescale 1ns / 1ps

module met_seq import met_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          out_free,
   input  stat_type      stat,
   output ctrl_word_type ctrl
);

   step_type step_ff, step_in;
   logic     taken;

   always_comb begin
      ctrl = met_ucode(step_ff);
   end

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:   taken = 1'b1;
         COND_REQ:      taken = req_valid;
         COND_SKIP:     taken = stat.skip_loop;
         COND_EXIT:     taken = stat.loop_exit;
         COND_OUT_FREE: taken = out_free;
         default:       taken = 1'b0;
      endcase
      step_in = taken ? ctrl.target : ctrl.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* src/mandelbrot_escape_time_top.sv */
`timescale 1ns / 1ps

// Mandelbrot escape-time counter, one pixel per request. The pixel maps to c in signed
// Q4.FRAC_BITS; a point inside the main cardioid disc returns the limit at once with
// bulb_shortcut set, otherwise z = z*z + c is iterated until |z|^2 >= 4 or the limit.
// A microcoded sequencer steps a datapath of three two-stage multipliers. The loop makes
// count + 1 iteration passes when the point escapes, the limit when it does not, and
// none on the disc shortcut or a zero limit. Each pass steps through S_ITER_MUL,
// S_ITER_ACC and S_ITER_STEP: the two register stages of the multipliers plus the z
// update. A finished result waits in an output register, so the next request is taken
// while it is still unread. Configuration must be written only while no request is in
// flight; the block itself does not enforce this.
module mandelbrot_escape_time_top import met_pkg::*; #(
   parameter int DIM_BITS  = DEF_DIM_BITS,
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   parameter int ITER_BITS = DEF_ITER_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   met_req_if.sink               req,
   met_rsp_if.source             rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type              cfg_ff, cfg_in;
   logic                 out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0]   out_count_ff, out_count_in;
   logic                 out_bulb_ff, out_bulb_in;

   ctrl_word_type        ctrl;
   stat_type             stat;
   logic [ITER_BITS-1:0] count;
   logic                 bulb;
   logic                 out_free;
   logic                 req_take;
   logic                 emit_load;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COLUMN_OFFSET:   cfg_in.column_offset   = csr_wdata[COL_OFS_W-1:0];
            CSR_ROW_OFFSET:      cfg_in.row_offset      = csr_wdata[ROW_OFS_W-1:0];
            CSR_X_STEP:          cfg_in.x_step          = csr_wdata[STEP_W-1:0];
            CSR_Y_STEP:          cfg_in.y_step          = csr_wdata[STEP_W-1:0];
            CSR_ITERATION_LIMIT: cfg_in.iteration_limit = csr_wdata[LIMIT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_offset   <= RST_COL_OFS;
         cfg_ff.row_offset      <= RST_ROW_OFS;
         cfg_ff.x_step          <= RST_X_STEP;
         cfg_ff.y_step          <= RST_Y_STEP;
         cfg_ff.iteration_limit <= RST_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign out_free  = !out_valid_ff || rsp.ready;
   assign req_take  = ctrl.take_req && req.valid;
   assign emit_load = ctrl.emit && out_free;

   met_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .out_free  (out_free),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   met_dpath #(
      .DIM_BITS  (DIM_BITS),
      .FRAC_BITS (FRAC_BITS),
      .ITER_BITS (ITER_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cfg      (cfg_ff),
      .req_take (req_take),
      .pix_row  (DIM_BITS'(req.pixel_row)),
      .pix_col  (DIM_BITS'(req.pixel_col)),
      .stat     (stat),
      .count    (count),
      .bulb     (bulb)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      out_count_in = out_count_ff;
      out_bulb_in  = out_bulb_ff;
      if (emit_load) begin
         out_valid_in = 1'b1;
         out_count_in = COUNT_W'(count);
         out_bulb_in  = bulb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_count_ff <= out_count_in;
      out_bulb_ff  <= out_bulb_in;
   end

   assign req.ready           = ctrl.take_req;
   assign rsp.valid           = out_valid_ff;
   assign rsp.iteration_count = out_count_ff;
   assign rsp.bulb_shortcut   = out_bulb_ff;

endmodule
